[sv/ccr_pkg.sv]
// ccr_pkg: shared types and constants of the circle column rasterizer
// no dependencies; imported by the stream interfaces and all ccr modules
`default_nettype none

package ccr_pkg;

  // fixed field widths of the stream payloads
  localparam int unsigned ColW = 14;
  localparam int unsigned RowW = 14;
  localparam int unsigned ModeW = 3;
  localparam int unsigned RegIdxW = 2;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_CENTER_X = 2'd0;
  localparam logic [RegIdxW-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [RegIdxW-1:0] REG_RADIUS = 2'd2;
  localparam logic [RegIdxW-1:0] REG_ARC_MODE = 2'd3;

  // arc modes
  localparam logic [ModeW-1:0] ARC_FULL = 3'd0;
  localparam logic [ModeW-1:0] ARC_UPPER = 3'd1;
  localparam logic [ModeW-1:0] ARC_LOWER = 3'd2;
  localparam logic [ModeW-1:0] ARC_LOWER_LEFT = 3'd3;
  localparam logic [ModeW-1:0] ARC_UPPER_LEFT = 3'd4;
  localparam logic [ModeW-1:0] ARC_LOWER_RIGHT = 3'd5;
  localparam logic [ModeW-1:0] ARC_UPPER_RIGHT = 3'd6;
  localparam logic [ModeW-1:0] ARC_NONE = 3'd7;

  // per-column control bits that ride along the pipeline
  typedef struct packed {
    logic span;
    logic up;
    logic dn;
  } ccr_flags_t;

endpackage

`default_nettype wire

[sv/ccr_col_if.sv]
// ccr_col_if: column request stream (valid/ready with a signed column)
// depends on ccr_pkg
`default_nettype none

interface ccr_col_if
  import ccr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [ColW-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface

`default_nettype wire

[sv/ccr_row_if.sv]
// ccr_row_if: arc pixel result stream (valid/ready with span, plot flags and rows)
// depends on ccr_pkg
`default_nettype none

interface ccr_row_if
  import ccr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   in_span;
  logic                   plot_upper;
  logic                   plot_lower;
  logic signed [RowW-1:0] upper_row;
  logic signed [RowW-1:0] lower_row;

  modport source (output valid, output in_span, output plot_upper, output plot_lower,
                  output upper_row, output lower_row, input ready);
  modport sink (input valid, input in_span, input plot_upper, input plot_lower,
                input upper_row, input lower_row, output ready);
endinterface

`default_nettype wire

[sv/circle_column_rasterizer_unit.sv]
// Circle column rasterizer: for each requested column x, the upper and lower
// arc rows of a configured circle, y0 + floor(sqrt D) and y0 - sqrt D truncated
// toward zero, with D = r*r - (x - x0)^2.
// Channels: col_i carries one signed column per beat; row_o returns exactly one
// beat per column, in order, with in_span, the two plot flags and both rows.
// Columns outside the arc mode's span return all zeros.
// Configuration: cfg_we_i/cfg_index_i/cfg_data_i write center_x, center_y,
// circle_radius and arc_mode; write only while no column is in flight.
// Pipeline: a column passes COORD_BITS + 3 registers (input stage, square,
// subtract, one root bit per stage over COORD_BITS - 1 stages, output register)
// on its way from col_i to row_o.
// Throughput: one column per cycle while row_o is ready. Every stage holds its
// own valid bit, so a stall on row_o fills bubbles first and col_i.ready drops
// only when all stages hold data; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears all
// configuration registers to zero.
// depends on ccr_pkg, ccr_col_if, ccr_row_if and ccr_sqrt_pipe
`default_nettype none

module circle_column_rasterizer_unit
  import ccr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [RegIdxW-1:0]     cfg_index_i,
  input  wire logic [COORD_BITS-1:0]  cfg_data_i,
  ccr_col_if.sink                     col_i,
  ccr_row_if.source                   row_o
);

  localparam int unsigned RootW = COORD_BITS - 1;
  localparam int unsigned SqW = 2 * RootW;
  localparam int unsigned XW = (COORD_BITS + 2 > ColW + 1) ? COORD_BITS + 2 : ColW + 1;
  localparam int unsigned SW = (COORD_BITS + 2 > RowW) ? COORD_BITS + 2 : RowW;

  // configuration
  logic [COORD_BITS-1:0] center_x_q;
  logic [COORD_BITS-1:0] center_y_q;
  logic [RootW-1:0]      radius_q;
  logic [ModeW-1:0]      arc_mode_q;
  logic [SqW-1:0]        rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q <= '0;
      arc_mode_q <= ARC_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_RADIUS:   radius_q <= cfg_data_i[RootW-1:0];
        REG_ARC_MODE: arc_mode_q <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // r*r is registered, so it follows the radius register in the next cycle
  always_ff @(posedge clk_i) begin
    rsq_q <= radius_q * radius_q;
  end

  // ready chain
  logic s1_rdy, s2_rdy, s3_rdy, sq_rdy, out_rdy;
  logic v1_q, v2_q, v3_q, out_v_q;

  // stage 1: span test and |x - x0|
  logic signed [XW-1:0] x_s, x0_s, r_s, lo_s, hi_s, dx_s, adx_s;
  ccr_flags_t           flags1_d, flags1_q;
  logic [RootW-1:0]     adx_d, adx_q;

  always_comb begin
    x_s = XW'(col_i.column);
    x0_s = XW'(center_x_q);
    r_s = XW'(radius_q);
    unique case (arc_mode_q)
      ARC_LOWER_LEFT, ARC_UPPER_LEFT: begin
        lo_s = x0_s - r_s;
        hi_s = x0_s;
      end
      ARC_LOWER_RIGHT, ARC_UPPER_RIGHT: begin
        lo_s = x0_s;
        hi_s = x0_s + r_s;
      end
      default: begin
        lo_s = x0_s - r_s;
        hi_s = x0_s + r_s;
      end
    endcase
    unique case (arc_mode_q)
      ARC_FULL: begin
        flags1_d.up = 1'b1;
        flags1_d.dn = 1'b1;
      end
      ARC_UPPER, ARC_UPPER_LEFT, ARC_UPPER_RIGHT: begin
        flags1_d.up = 1'b1;
        flags1_d.dn = 1'b0;
      end
      ARC_LOWER, ARC_LOWER_LEFT, ARC_LOWER_RIGHT: begin
        flags1_d.up = 1'b0;
        flags1_d.dn = 1'b1;
      end
      default: begin
        flags1_d.up = 1'b0;
        flags1_d.dn = 1'b0;
      end
    endcase
    flags1_d.span = (x_s >= lo_s) && (x_s < hi_s);
    dx_s = x_s - x0_s;
    adx_s = dx_s[XW-1] ? -dx_s : dx_s;
    // inside the span |dx| <= r, so it fits the radius width
    adx_d = flags1_d.span ? adx_s[RootW-1:0] : '0;
  end

  assign s1_rdy = !v1_q || s2_rdy;
  assign col_i.ready = s1_rdy;

  // stage 2: dx squared
  ccr_flags_t     flags2_q;
  logic [SqW-1:0] dxsq_q;
  assign s2_rdy = !v2_q || s3_rdy;

  // stage 3: radicand
  ccr_flags_t     flags3_q;
  logic [SqW-1:0] rad_q;
  assign s3_rdy = !v3_q || sq_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_q <= col_i.valid;
      end
      if (s2_rdy) begin
        v2_q <= v1_q;
      end
      if (s3_rdy) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && col_i.valid) begin
      flags1_q <= flags1_d;
      adx_q <= adx_d;
    end
    if (s2_rdy && v1_q) begin
      flags2_q <= flags1_q;
      dxsq_q <= adx_q * adx_q;
    end
    if (s3_rdy && v2_q) begin
      flags3_q <= flags2_q;
      // never negative inside the span; outside, dx is forced to zero
      rad_q <= rsq_q - dxsq_q;
    end
  end

  // root stages
  logic             sq_v;
  logic [RootW-1:0] sq_root;
  logic             sq_exact;
  ccr_flags_t       sq_flags;

  ccr_sqrt_pipe #(
    .ROOT_BITS(RootW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3_q),
    .ready_o    (sq_rdy),
    .radicand_i (rad_q),
    .flags_i    (flags3_q),
    .valid_o    (sq_v),
    .ready_i    (out_rdy),
    .root_o     (sq_root),
    .exact_o    (sq_exact),
    .flags_o    (sq_flags)
  );

  // output stage: rows, truncation toward zero on the lower row
  logic signed [SW-1:0] y0_s, q_s, c_s, up_s, lo_ceil_s, lo_s2;
  logic                 span_q, up_q, dn_q;
  logic [RowW-1:0]      up_row_q, lo_row_q;

  always_comb begin
    y0_s = SW'(center_y_q);
    q_s = SW'(sq_root);
    c_s = q_s + SW'(!sq_exact);
    up_s = y0_s + q_s;
    lo_ceil_s = y0_s - c_s;
    lo_s2 = lo_ceil_s[SW-1] ? (y0_s - q_s) : lo_ceil_s;
  end

  assign out_rdy = !out_v_q || row_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && sq_v) begin
      span_q <= sq_flags.span;
      up_q <= sq_flags.span && sq_flags.up;
      dn_q <= sq_flags.span && sq_flags.dn;
      up_row_q <= sq_flags.span ? up_s[RowW-1:0] : '0;
      lo_row_q <= sq_flags.span ? lo_s2[RowW-1:0] : '0;
    end
  end

  assign row_o.valid = out_v_q;
  assign row_o.in_span = span_q;
  assign row_o.plot_upper = up_q;
  assign row_o.plot_lower = dn_q;
  assign row_o.upper_row = up_row_q;
  assign row_o.lower_row = lo_row_q;

endmodule

`default_nettype wire

[sv/ccr_sqrt_pipe.sv]
// ccr_sqrt_pipe: pipelined integer square root, one root bit per stage
// depends on ccr_pkg (flags struct carried alongside each beat)
`default_nettype none

module ccr_sqrt_pipe
  import ccr_pkg::*;
#(
  parameter int unsigned ROOT_BITS = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic [2*ROOT_BITS-1:0] radicand_i,
  input  wire ccr_flags_t             flags_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic [ROOT_BITS-1:0]        root_o,
  output logic                        exact_o,
  output ccr_flags_t                  flags_o
);

  localparam int unsigned RemW = 2 * ROOT_BITS;
  localparam int unsigned TrialW = RemW + 1;

  logic [ROOT_BITS-1:0] v_q;
  logic [ROOT_BITS:0]   rdy;
  logic [RemW-1:0]      rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  ccr_flags_t           flags_q[ROOT_BITS];

  assign rdy[ROOT_BITS] = ready_i;
  assign ready_o = rdy[0];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    localparam int unsigned Bit = ROOT_BITS - 1 - i;

    logic                 v_prev;
    logic [RemW-1:0]      rem_prev;
    logic [ROOT_BITS-1:0] root_prev;
    ccr_flags_t           flags_prev;
    logic [TrialW-1:0]    trial;
    logic                 take;
    logic [RemW-1:0]      rem_d;
    logic [ROOT_BITS-1:0] root_d;

    if (i == 0) begin : g_first
      assign v_prev = valid_i;
      assign rem_prev = radicand_i;
      assign root_prev = '0;
      assign flags_prev = flags_i;
    end else begin : g_next
      assign v_prev = v_q[i-1];
      assign rem_prev = rem_q[i-1];
      assign root_prev = root_q[i-1];
      assign flags_prev = flags_q[i-1];
    end

    // (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
    assign trial = (TrialW'(root_prev) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign take = TrialW'(rem_prev) >= trial;
    assign rem_d = take ? RemW'(TrialW'(rem_prev) - trial) : rem_prev;
    assign root_d = take ? (root_prev | (ROOT_BITS'(1) << Bit)) : root_prev;

    assign rdy[i] = !v_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_prev) begin
        rem_q[i] <= rem_d;
        root_q[i] <= root_d;
        flags_q[i] <= flags_prev;
      end
    end
  end

  assign valid_o = v_q[ROOT_BITS-1];
  assign root_o = root_q[ROOT_BITS-1];
  assign exact_o = (rem_q[ROOT_BITS-1] == '0);
  assign flags_o = flags_q[ROOT_BITS-1];

endmodule

`default_nettype wire

[dv/circle_column_rasterizer_unit_tb.sv]
// testbench for circle_column_rasterizer_unit: drives columns under varied circle setups
// and idling, predicts each arc beat in a scoreboard class and checks them in order
// depends on ccr_pkg, ccr_col_if, ccr_row_if and the rasterizer rtl
`timescale 1ns / 100ps

module circle_column_rasterizer_unit_tb
  import ccr_pkg::*;
();

  localparam int CoordBits = 12;

  typedef struct {
    logic signed [ColW-1:0] column;
    bit                     in_span;
    bit                     plot_upper;
    bit                     plot_lower;
    bit [RowW-1:0]          upper_row;
    bit [RowW-1:0]          lower_row;
  } arc_beat_t;

  class arc_scoreboard;
    bit [11:0]  cx;
    bit [11:0]  cy;
    bit [10:0]  rad;
    bit [2:0]   mode;
    arc_beat_t  due_beats[$];
    int         mismatches;
    int         shown;

    function new();
      cx = '0;
      cy = '0;
      rad = '0;
      mode = ARC_FULL;
      mismatches = 0;
      shown = 0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, bit [11:0] data);
      case (idx)
        REG_CENTER_X: cx = data;
        REG_CENTER_Y: cy = data;
        REG_RADIUS:   rad = data[10:0];
        REG_ARC_MODE: mode = data[2:0];
        default: ;
      endcase
    endfunction

    function longint floor_root(longint d);
      longint q;
      longint t;
      q = 0;
      for (int b = 11; b >= 0; b--) begin
        t = q | (longint'(1) << b);
        if (t * t <= d) q = t;
      end
      return q;
    endfunction

    function arc_beat_t predict(logic signed [ColW-1:0] col);
      arc_beat_t b;
      longint x, x0, y0, r, lo, hi, dx, d, q, c, up_r, dn_r;
      bit up, dn;
      x = col;
      x0 = cx;
      y0 = cy;
      r = rad;
      case (mode)
        ARC_LOWER_LEFT, ARC_UPPER_LEFT: begin
          lo = x0 - r;
          hi = x0;
        end
        ARC_LOWER_RIGHT, ARC_UPPER_RIGHT: begin
          lo = x0;
          hi = x0 + r;
        end
        default: begin
          lo = x0 - r;
          hi = x0 + r;
        end
      endcase
      case (mode)
        ARC_FULL: begin
          up = 1;
          dn = 1;
        end
        ARC_UPPER, ARC_UPPER_LEFT, ARC_UPPER_RIGHT: begin
          up = 1;
          dn = 0;
        end
        ARC_LOWER, ARC_LOWER_LEFT, ARC_LOWER_RIGHT: begin
          up = 0;
          dn = 1;
        end
        default: begin
          up = 0;
          dn = 0;
        end
      endcase
      b.column = col;
      b.in_span = 0;
      b.plot_upper = 0;
      b.plot_lower = 0;
      b.upper_row = '0;
      b.lower_row = '0;
      if (x >= lo && x < hi) begin
        dx = x - x0;
        d = r * r - dx * dx;
        if (d < 0) d = 0;
        q = floor_root(d);
        c = (q * q == d) ? q : q + 1;
        up_r = y0 + q;
        // truncation toward zero: a negative lower row falls back to the floor root
        dn_r = y0 - c;
        if (dn_r < 0) dn_r = y0 - q;
        b.in_span = 1;
        b.plot_upper = up;
        b.plot_lower = dn;
        b.upper_row = up_r[RowW-1:0];
        b.lower_row = dn_r[RowW-1:0];
      end
      return b;
    endfunction

    function void note_column(logic signed [ColW-1:0] col);
      due_beats.push_back(predict(col));
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    function void report(string field, logic signed [ColW-1:0] col, longint exp_v,
                         longint act_v);
      mismatches++;
      if (shown < 10) begin
        shown++;
        $display("mismatch column %0d %s: expected %0d got %0d", col, field, exp_v, act_v);
      end
    endfunction

    function void check_beat(logic span, logic up, logic dn, logic [RowW-1:0] up_row,
                             logic [RowW-1:0] dn_row);
      arc_beat_t e;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat: upper_row %0d lower_row %0d",
                   $signed(up_row), $signed(dn_row));
        end
        return;
      end
      e = due_beats.pop_front();
      if (span !== e.in_span) report("in_span", e.column, e.in_span, span);
      if (up !== e.plot_upper) report("plot_upper", e.column, e.plot_upper, up);
      if (dn !== e.plot_lower) report("plot_lower", e.column, e.plot_lower, dn);
      if (up_row !== e.upper_row)
        report("upper_row", e.column, $signed(e.upper_row), $signed(up_row));
      if (dn_row !== e.lower_row)
        report("lower_row", e.column, $signed(e.lower_row), $signed(dn_row));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [RegIdxW-1:0]    cfg_index;
  logic [CoordBits-1:0]  cfg_data;
  int                    send_idle_pct;
  int                    recv_stall_pct;

  ccr_col_if col_if ();
  ccr_row_if row_if ();

  arc_scoreboard sb = new();

  circle_column_rasterizer_unit #(
    .COORD_BITS(CoordBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .col_i      (col_if),
    .row_o      (row_if)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    col_if.valid = 1'b0;
    col_if.column = '0;
    row_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    row_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && col_if.valid && col_if.ready) sb.note_column(col_if.column);
  end

  always @(posedge clk_i) begin
    if (rst_ni && row_if.valid && row_if.ready)
      sb.check_beat(row_if.in_span, row_if.plot_upper, row_if.plot_lower,
                    row_if.upper_row, row_if.lower_row);
  end

  // waits for the pipeline to drain, then writes all four registers on consecutive edges
  task automatic cfg_apply(input bit [11:0] x0, input bit [11:0] y0,
                           input bit [11:0] rad_word, input bit [11:0] mode_word);
    col_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    cfg_we <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data <= x0;
    @(posedge clk_i);
    sb.set_reg(REG_CENTER_X, x0);
    cfg_index <= REG_CENTER_Y;
    cfg_data <= y0;
    @(posedge clk_i);
    sb.set_reg(REG_CENTER_Y, y0);
    cfg_index <= REG_RADIUS;
    cfg_data <= rad_word;
    @(posedge clk_i);
    sb.set_reg(REG_RADIUS, rad_word);
    cfg_index <= REG_ARC_MODE;
    cfg_data <= mode_word;
    @(posedge clk_i);
    sb.set_reg(REG_ARC_MODE, mode_word);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_column(input logic signed [ColW-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      col_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    col_if.valid <= 1'b1;
    col_if.column <= x;
    do @(posedge clk_i); while (!col_if.ready);
  endtask

  function automatic bit [11:0] pick_coord();
    case ($urandom_range(3))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic bit [11:0] pick_radius();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'd2047;
      2: return 12'hFFF;
      3: return 12'($urandom_range(20));
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    bit [11:0] x0, y0, rad_word, mode_word;
    int lo, hi;
    logic signed [ColW-1:0] x;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edges of the full span and extreme columns
    cfg_apply(12'd100, 12'd50, 12'd10, {9'd0, ARC_FULL});
    drive_column(14'sd90);
    drive_column(14'sd109);
    drive_column(14'sd110);
    drive_column(14'sd89);
    drive_column(14'sd100);
    drive_column(14'sd99);
    drive_column(-14'sd8192);
    drive_column(14'sd8191);
    drive_column(14'sd0);

    // center near row zero, lower row would go negative
    cfg_apply(12'd20, 12'd0, 12'd10, {9'd0, ARC_LOWER});
    drive_column(14'sd11);
    drive_column(14'sd15);
    drive_column(14'sd29);

    // zero radius: every span empty
    cfg_apply(12'd500, 12'd500, 12'd0, {9'd0, ARC_FULL});
    drive_column(14'sd500);

    // each arc mode but ARC_FULL on both sides of the center
    for (int m = ARC_UPPER; m <= ARC_NONE; m++) begin
      cfg_apply(12'd2000, 12'd2000, 12'd300, 12'(m));
      drive_column(14'sd1700);
      drive_column(14'sd2150);
    end

    for (int p = 0; p < 24; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      x0 = pick_coord();
      y0 = pick_coord();
      rad_word = pick_radius();
      mode_word = 12'($urandom);
      if (p % 2 == 0) mode_word[2:0] = 3'((p / 2) % 8);
      cfg_apply(x0, y0, rad_word, mode_word);
      lo = int'(x0) - int'(rad_word[10:0]) - 2;
      hi = int'(x0) + int'(rad_word[10:0]) + 1;
      for (int i = 0; i < 26; i++) begin
        if (p == 5 && i == 13) begin
          // hold off until the pipeline has drained
          col_if.valid <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        if ($urandom_range(9) < 7) x = ColW'(lo + $urandom_range(hi - lo));
        else x = ColW'($urandom);
        drive_column(x);
      end
    end

    col_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[circle_column_rasterizer_unit.f]
sv/ccr_pkg.sv
sv/ccr_col_if.sv
sv/ccr_row_if.sv
sv/ccr_sqrt_pipe.sv
sv/circle_column_rasterizer_unit.sv
dv/circle_column_rasterizer_unit_tb.sv
